// File: hw/rtl/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

    // Array geometry
    localparam int MEMORY_BYTES = 524288;
    localparam int SECTOR_BYTES = 4096;
    localparam int BLOCK_BYTES  = 65536;

    localparam int ADDR_W  = $clog2(MEMORY_BYTES);
    localparam int BLK_LSB = $clog2(BLOCK_BYTES);
    localparam int NUM_BLK = MEMORY_BYTES / BLOCK_BYTES;
    localparam int BLK_W   = $clog2(NUM_BLK);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [2:0]        t_lock;

    localparam t_addr SECTOR_MASK = t_addr'(SECTOR_BYTES - 1);
    localparam t_addr BLOCK_MASK  = t_addr'(BLOCK_BYTES - 1);
    localparam t_addr FULL_MASK   = t_addr'(MEMORY_BYTES - 1);

    // Lock register window
    localparam logic [31:0] LOCK_ADDR_MASK  = 32'hFFF8_FFFF;
    localparam logic [31:0] LOCK_ADDR_MATCH = 32'hFFB8_0002;
    localparam t_lock       LOCK_RESET      = 3'b001;

    // Lock register bits
    localparam int LK_WRITE = 0;
    localparam int LK_DOWN  = 1;
    localparam int LK_READ  = 2;

    // Command sequence addresses and bytes
    localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
    localparam logic [7:0]  CMD_UNLOCK1  = 8'hAA;
    localparam logic [7:0]  CMD_UNLOCK2  = 8'h55;
    localparam logic [7:0]  CMD_ERASE    = 8'h80;
    localparam logic [7:0]  CMD_PROGRAM  = 8'hA0;
    localparam logic [7:0]  CMD_ID       = 8'h90;
    localparam logic [7:0]  CMD_ID_EXIT  = 8'hF0;
    localparam logic [7:0]  CMD_SECTOR   = 8'h30;
    localparam logic [7:0]  CMD_BLOCK    = 8'h50;

    localparam logic [7:0]  BYTE_ERASED  = 8'hFF;
    localparam logic [7:0]  BYTE_CLEAR   = 8'h00;

    // Bus operation codes
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // Command sequence position
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_UNLOCK1 = 3'd1,
        PH_UNLOCK2 = 3'd2,
        PH_ERASE1  = 3'd3,
        PH_ERASE2  = 3'd4,
        PH_ERASE3  = 3'd5,
        PH_PROGRAM = 3'd6,
        PH_ID      = 3'd7
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PROG,
        ST_ERASE
    } t_state;

    // Controller to array port
    typedef struct packed {
        logic       re;
        logic       we;
        t_addr      addr;
        logic [7:0] wdata;
    } t_ram_cmd;

    // Controller to output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_res;

    // Manufacturer and device ID bytes
    function automatic logic [7:0] id_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = 8'h9D;
            2'd1:    b = 8'h6E;
            default: b = 8'h7F;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fcc_if.sv
`default_nettype none

// Bus access request channel
interface fcc_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

// Read data channel
interface fcc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fcc_ram.sv
`default_nettype none

module fcc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_re,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fcc_ctrl.sv
`default_nettype none

module fcc_ctrl
    import fcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    fcc_req_if.sink         i_req,
    output      t_res       o_res,
    input  wire logic       i_res_ready,
    output      t_ram_cmd   o_ram,
    input  wire logic [7:0] i_ram_rdata
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    t_lock      r_lock [NUM_BLK];
    t_addr      r_addr;
    t_addr      r_mask;
    logic       r_fill;
    logic [7:0] r_wdata;
    logic       r_src_mem;
    logic [7:0] r_const;

    logic        acc;
    logic        is_wr;
    logic        win;
    logic        lreg;
    t_blk        lidx;
    t_addr       off;
    logic [15:0] low;
    logic [7:0]  d;
    t_lock       lr;
    logic        pgm_go;
    logic        ers_go;
    logic        sweep_last;

    // Request decode; a request is taken only in the idle state
    always_comb begin
        acc   = i_req.valid && (r_state == ST_IDLE);
        is_wr = (t_op'(i_req.operation) == OP_WRITE);
        win   = &i_req.address[31:ADDR_W];
        lreg  = ((i_req.address & LOCK_ADDR_MASK) == LOCK_ADDR_MATCH);
        lidx  = i_req.address[BLK_LSB +: BLK_W];
        off   = i_req.address[ADDR_W-1:0];
        low   = i_req.address[15:0];
        d     = i_req.write_data;
        lr    = r_lock[off[BLK_LSB +: BLK_W]];
        pgm_go = acc && is_wr && win && (r_phase == PH_PROGRAM) && !lr[LK_WRITE];
        ers_go = acc && is_wr && win && (r_phase == PH_ERASE3) && !lr[LK_WRITE]
                 && ((d == CMD_SECTOR) || (d == CMD_BLOCK));
        sweep_last = ((r_addr & r_mask) == r_mask);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc && !is_wr) begin
                    n_state = ST_READ;
                end else if (pgm_go) begin
                    n_state = ST_PROG;
                end else if (ers_go) begin
                    n_state = ST_ERASE;
                end
            end
            ST_READ: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            ST_PROG: begin
                n_state = ST_IDLE;
            end
            ST_ERASE: begin
                if (sweep_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake, result and array port
    always_comb begin
        i_req.ready   = 1'b0;
        o_res.valid   = 1'b0;
        o_res.data    = r_src_mem ? i_ram_rdata : r_const;
        o_ram.re      = 1'b0;
        o_ram.we      = 1'b0;
        o_ram.addr    = r_addr;
        o_ram.wdata   = r_fill ? BYTE_ERASED : BYTE_CLEAR;
        unique case (r_state)
            ST_CLEAR, ST_ERASE: begin
                o_ram.we = 1'b1;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                o_ram.re    = acc;
                o_ram.addr  = off;
            end
            ST_READ: begin
                o_res.valid = 1'b1;
            end
            ST_PROG: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = i_ram_rdata & r_wdata;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    // Command sequence
    always_comb begin
        n_phase = r_phase;
        if (acc && win) begin
            if (!is_wr) begin
                if (r_phase != PH_ID) n_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (low == ADDR_UNLOCK1 && d == CMD_UNLOCK1) n_phase = PH_UNLOCK1;
                    end
                    PH_UNLOCK1: begin
                        n_phase = (low == ADDR_UNLOCK2 && d == CMD_UNLOCK2) ?
                                  PH_UNLOCK2 : PH_IDLE;
                    end
                    PH_UNLOCK2: begin
                        n_phase = PH_IDLE;
                        if (low == ADDR_UNLOCK1) begin
                            if (d == CMD_ERASE)        n_phase = PH_ERASE1;
                            else if (d == CMD_PROGRAM) n_phase = PH_PROGRAM;
                            else if (d == CMD_ID)      n_phase = PH_ID;
                            else if (d == CMD_UNLOCK1) n_phase = PH_UNLOCK1;
                        end
                    end
                    PH_ERASE1: begin
                        n_phase = (low == ADDR_UNLOCK1 && d == CMD_UNLOCK1) ?
                                  PH_ERASE2 : PH_IDLE;
                    end
                    PH_ERASE2: begin
                        n_phase = (low == ADDR_UNLOCK2 && d == CMD_UNLOCK2) ?
                                  PH_ERASE3 : PH_IDLE;
                    end
                    PH_ERASE3, PH_PROGRAM: begin
                        n_phase = PH_IDLE;
                    end
                    PH_ID: begin
                        if (d == CMD_ID_EXIT) n_phase = PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_mask  <= FULL_MASK;
            r_fill  <= 1'b0;
            for (int i = 0; i < NUM_BLK; i++) begin
                r_lock[i] <= LOCK_RESET;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;

            // Lock register write, blocked by lock-down
            if (acc && is_wr && !win && lreg && !r_lock[lidx][LK_DOWN]) begin
                r_lock[lidx] <= d[2:0];
            end

            // Sweep address: advances on fills, loads on program or erase start
            if (r_state == ST_CLEAR || r_state == ST_ERASE) begin
                r_addr <= r_addr + t_addr'(1);
            end else if (pgm_go) begin
                r_addr <= off;
            end else if (ers_go) begin
                r_fill <= 1'b1;
                if (d == CMD_SECTOR) begin
                    r_addr <= off & ~SECTOR_MASK;
                    r_mask <= SECTOR_MASK;
                end else begin
                    r_addr <= off & ~BLOCK_MASK;
                    r_mask <= BLOCK_MASK;
                end
            end
        end
    end

    // Read source and program data
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_wdata   <= d;
            r_src_mem <= win && (r_phase != PH_ID) && !lr[LK_READ];
            if (!win) begin
                r_const <= lreg ? {5'b0, r_lock[lidx]} : BYTE_ERASED;
            end else if (r_phase == PH_ID) begin
                r_const <= id_byte(i_req.address[1:0]);
            end else begin
                r_const <= BYTE_ERASED;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/flash_command_controller_top.sv
`default_nettype none

// Parallel flash command controller with a 512 KiB byte array.
// i_req carries one bus access per request: operation (0 read, 1 byte
// write), 32-bit address and write_data. o_rsp returns read_data, one
// response per read request and none per write.
// Array window is 0xFFF80000..0xFFFFFFFF; lock registers sit below it.
// Access flow, set by the single array port and its sweep counter:
//   read      array read is registered, then the response goes to the output register
//   write     command writes need no array access; byte program reads, then writes back
//   erase     a 4096-byte sector or a 64 KiB block,
//             one byte written per cycle
// Reset: i_rst_n is synchronous, active low. After reset the controller runs
// a clearing pass zeroing the whole array; i_req.ready stays low until it
// ends. Lock registers come up write locked.
// Stall: the response sits in an output register; writes are still taken
// while it waits. A read waits in the controller until the register frees.
module flash_command_controller_top
    import fcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcc_req_if.sink   i_req,
    fcc_rsp_if.source o_rsp
);

    t_ram_cmd   ram_cmd;
    logic [7:0] ram_rdata;
    t_res       res;
    logic       res_ready;

    logic       r_out_valid;
    logic [7:0] r_out_data;

    fcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_ram       (ram_cmd),
        .i_ram_rdata (ram_rdata)
    );

    fcc_ram #(
        .DEPTH (MEMORY_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (ram_cmd.re),
        .i_we    (ram_cmd.we),
        .i_addr  (ram_cmd.addr),
        .i_wdata (ram_cmd.wdata),
        .o_rdata (ram_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

endmodule

`default_nettype wire

// File: verif/tb_flash_command_controller_top.sv
module tb_flash_command_controller_top;
    import fcc_pkg::*;

    localparam logic [31:0] WINDOW_BASE = 32'hFFF8_0000;
    // ID bytes packed low byte first, picked by address bits 1:0
    localparam logic [31:0] ID_BYTES    = 32'h7F7F_6E9D;
    // longest quiet stretch is the clearing pass after reset
    localparam int          STALL_LIMIT = 2_000_000;
    localparam int          ITEM_GOAL   = 2000;
    localparam int          CALM_TAIL   = 300;
    localparam int          DRAIN_EVERY = 500;
    localparam int          MAX_PRINTS  = 40;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [7:0]  data;
        logic        known;
        logic [7:0]  rd;
    } t_row;

    localparam int N_DIRECTED = 27;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // array and lock registers straight after reset
        '{OP_READ,  32'hFFF8_0000, 8'h00,       1'b1, 8'h00},
        '{OP_READ,  32'hFFFF_FFFF, 8'hFF,       1'b1, 8'h00},
        '{OP_READ,  32'h0000_0000, 8'h00,       1'b1, 8'hFF},
        '{OP_READ,  32'hFFB8_0002, 8'h00,       1'b1, 8'h01},
        // open block 0, lock down block 7 with writes open
        '{OP_WRITE, 32'hFFB8_0002, 8'hF8,       1'b0, 8'h00},
        '{OP_WRITE, 32'hFFBF_0002, 8'h02,       1'b0, 8'h00},
        '{OP_WRITE, 32'hFFBF_0002, 8'h07,       1'b0, 8'h00},
        '{OP_READ,  32'hFFBF_0002, 8'h00,       1'b1, 8'h02},
        // unlock, restart with a fresh first unlock, then block erase of block 0
        '{OP_WRITE, 32'hFFF8_5555, CMD_UNLOCK1, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_2AAA, CMD_UNLOCK2, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_5555, CMD_UNLOCK1, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_2AAA, CMD_UNLOCK2, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_5555, CMD_ERASE,   1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_5555, CMD_UNLOCK1, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_2AAA, CMD_UNLOCK2, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_0000, CMD_BLOCK,   1'b0, 8'h00},
        // byte program into the erased block
        '{OP_WRITE, 32'hFFF8_5555, CMD_UNLOCK1, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_2AAA, CMD_UNLOCK2, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_5555, CMD_PROGRAM, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_0123, 8'h5A,       1'b0, 8'h00},
        '{OP_READ,  32'hFFF8_0123, 8'h00,       1'b1, 8'h5A},
        // ID mode: the ID bytes read back, only the exit byte leaves
        '{OP_WRITE, 32'hFFF8_5555, CMD_UNLOCK1, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_2AAA, CMD_UNLOCK2, 1'b0, 8'h00},
        '{OP_WRITE, 32'hFFF8_5555, CMD_ID,      1'b0, 8'h00},
        '{OP_READ,  32'hFFF8_0000, 8'h00,       1'b1, 8'h9D},
        '{OP_READ,  32'hFFF8_0003, 8'h00,       1'b1, 8'h7F},
        '{OP_WRITE, 32'hFFF8_0000, CMD_ID_EXIT, 1'b0, 8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcc_req_if req_bus ();
    fcc_rsp_if rsp_bus ();

    flash_command_controller_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // flash image and command state as the block should hold them
    logic [7:0] model_bytes [MEMORY_BYTES];
    t_lock      model_locks [NUM_BLK];
    t_phase     model_phase;

    logic [7:0] expected_reads [$];
    t_addr      erased_bases [$];

    int n_errors     = 0;
    int n_items      = 0;
    int idle_pct     = 0;
    int hold_left    = 0;
    int spoil_in     = -1;
    int sectors_left = 24;
    int blocks_left  = 1;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (n_errors < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // one bus access applied to the flash image; rdata holds the byte a read returns
    task automatic flash_model_access(input t_op op, input logic [31:0] addr,
                                      input logic [7:0] wdata, output logic [7:0] rdata);
        t_addr       off;
        t_blk        blk;
        t_blk        lreg;
        logic [15:0] low;
        t_addr       wipe_base;
        int          wipe_len;
        int          n;
        off       = addr[ADDR_W-1:0];
        blk       = off[ADDR_W-1:BLK_LSB];
        lreg      = addr[16 +: BLK_W];
        low       = addr[15:0];
        rdata     = BYTE_ERASED;
        wipe_base = '0;
        wipe_len  = 0;
        if (addr < WINDOW_BASE) begin
            // below the window only the lock registers respond
            if ((addr & LOCK_ADDR_MASK) == LOCK_ADDR_MATCH) begin
                if (op == OP_READ) rdata = 8'(model_locks[lreg]);
                else if (!model_locks[lreg][LK_DOWN]) model_locks[lreg] = wdata[2:0];
            end
        end else if (op == OP_READ) begin
            if (model_phase == PH_ID) begin
                rdata = ID_BYTES[8*off[1:0] +: 8];
            end else begin
                model_phase = PH_IDLE;
                if (!model_locks[blk][LK_READ]) rdata = model_bytes[off];
            end
        end else begin
            case (model_phase)
                PH_IDLE: begin
                    if (low == ADDR_UNLOCK1 && wdata == CMD_UNLOCK1) model_phase = PH_UNLOCK1;
                end
                PH_UNLOCK1: begin
                    model_phase = (low == ADDR_UNLOCK2 && wdata == CMD_UNLOCK2) ?
                                  PH_UNLOCK2 : PH_IDLE;
                end
                PH_UNLOCK2: begin
                    model_phase = PH_IDLE;
                    if (low == ADDR_UNLOCK1) begin
                        case (wdata)
                            CMD_ERASE:   model_phase = PH_ERASE1;
                            CMD_PROGRAM: model_phase = PH_PROGRAM;
                            CMD_ID:      model_phase = PH_ID;
                            CMD_UNLOCK1: model_phase = PH_UNLOCK1;
                            default:     model_phase = PH_IDLE;
                        endcase
                    end
                end
                PH_PROGRAM: begin
                    // program can only clear bits
                    if (!model_locks[blk][LK_WRITE]) model_bytes[off] = model_bytes[off] & wdata;
                    model_phase = PH_IDLE;
                end
                PH_ERASE1: begin
                    model_phase = (low == ADDR_UNLOCK1 && wdata == CMD_UNLOCK1) ?
                                  PH_ERASE2 : PH_IDLE;
                end
                PH_ERASE2: begin
                    model_phase = (low == ADDR_UNLOCK2 && wdata == CMD_UNLOCK2) ?
                                  PH_ERASE3 : PH_IDLE;
                end
                PH_ERASE3: begin
                    if (!model_locks[blk][LK_WRITE]) begin
                        if (wdata == CMD_SECTOR) begin
                            wipe_base = off & ~SECTOR_MASK;
                            wipe_len  = SECTOR_BYTES;
                        end else if (wdata == CMD_BLOCK) begin
                            wipe_base = off & ~BLOCK_MASK;
                            wipe_len  = BLOCK_BYTES;
                        end
                    end
                    model_phase = PH_IDLE;
                end
                default: begin
                    if (wdata == CMD_ID_EXIT) model_phase = PH_IDLE;
                end
            endcase
            for (n = 0; n < wipe_len; n++) model_bytes[wipe_base + t_addr'(n)] = BYTE_ERASED;
        end
    endtask

    function automatic logic [31:0] win(input t_addr off);
        return WINDOW_BASE | 32'(off);
    endfunction

    // command cycle address: only the low 16 bits matter, block is free
    function automatic logic [31:0] cmd_addr(input logic [15:0] low);
        return win({t_blk'($urandom), low});
    endfunction

    // mostly bytes near the start of erased sectors and blocks, where programs show up
    function automatic t_addr hot_offset();
        t_addr off;
        off = t_addr'($urandom);
        if (erased_bases.size() != 0 && $urandom_range(0, 3) != 0)
            off = erased_bases[$urandom_range(0, erased_bases.size() - 1)] +
                  t_addr'($urandom_range(0, 63));
        return off;
    endfunction

    // drive one request from a falling edge, wait for it to be taken, predict it
    task automatic put_request(input t_op op, input logic [31:0] addr, input logic [7:0] data,
                               input logic known, input logic [7:0] known_rd);
        logic [7:0] rd;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.operation  <= op;
        req_bus.address    <= addr;
        req_bus.write_data <= data;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        flash_model_access(op, addr, data, rd);
        if (op == OP_READ) expected_reads.push_back(known ? known_rd : rd);
        // plain writes below the window change nothing
        if (op == OP_READ || addr >= WINDOW_BASE ||
            (addr & LOCK_ADDR_MASK) == LOCK_ADDR_MATCH)
            n_items++;
        @(negedge i_clk);
    endtask

    // command write that may be swapped for a random request to break the sequence
    task automatic seq_write(input logic [31:0] addr, input logic [7:0] data);
        if (spoil_in == 0)
            put_request(t_op'($urandom_range(0, 1)), win(t_addr'($urandom)), 8'($urandom),
                        1'b0, 8'h00);
        else
            put_request(OP_WRITE, addr, data, 1'b0, 8'h00);
        spoil_in--;
    endtask

    task automatic unlock_pair();
        seq_write(cmd_addr(ADDR_UNLOCK1), CMD_UNLOCK1);
        seq_write(cmd_addr(ADDR_UNLOCK2), CMD_UNLOCK2);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // response side: stall bursts while idling is on
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                hold_left = $urandom_range(0, 18);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // compare each returned byte with the oldest outstanding read
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_reads.size() == 0) begin
                flag_error($sformatf("read data %02h with no read outstanding",
                                     rsp_bus.read_data));
            end else begin
                want = expected_reads.pop_front();
                if (rsp_bus.read_data !== want)
                    flag_error($sformatf("read_data %02h, expected %02h",
                                         rsp_bus.read_data, want));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("tb_flash_command_controller_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int          k;
        int          pick;
        int          reps;
        int          next_drain;
        t_addr       off;
        t_blk        b;
        logic [7:0]  d;
        logic [31:0] a;

        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_READ;
        req_bus.address    = '0;
        req_bus.write_data = '0;
        for (k = 0; k < MEMORY_BYTES; k++) model_bytes[k] = BYTE_CLEAR;
        for (k = 0; k < NUM_BLK; k++) model_locks[k] = LOCK_RESET;
        model_phase = PH_IDLE;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (k = 0; k < N_DIRECTED; k++)
            put_request(DIRECTED[k].op, DIRECTED[k].addr, DIRECTED[k].data,
                        DIRECTED[k].known, DIRECTED[k].rd);
        erased_bases.push_back('0);

        // random command sequences with noise mixed in
        next_drain = DRAIN_EVERY;
        while (n_items < ITEM_GOAL) begin
            if (n_items >= next_drain) begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
            if (n_items >= ITEM_GOAL - CALM_TAIL) idle_pct = 0;
            else if ($urandom_range(0, 15) == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            spoil_in = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : -1;
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                // byte program
                unlock_pair();
                seq_write(cmd_addr(ADDR_UNLOCK1), CMD_PROGRAM);
                seq_write(win(hot_offset()), 8'($urandom));
            end else if (pick < 46) begin
                // array reads
                reps = $urandom_range(1, 3);
                repeat (reps) put_request(OP_READ, win(hot_offset()), 8'($urandom), 1'b0, 8'h00);
            end else if (pick < 54) begin
                // erase: sector or block within budget, otherwise an unknown command byte
                off = ($urandom_range(0, 1) != 0) ? hot_offset() : t_addr'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: d = CMD_SECTOR;
                    6:                d = CMD_BLOCK;
                    default:          d = 8'($urandom);
                endcase
                if (!model_locks[off[ADDR_W-1:BLK_LSB]][LK_WRITE] &&
                    (d == CMD_SECTOR || d == CMD_BLOCK)) begin
                    if ((d == CMD_SECTOR ? sectors_left : blocks_left) == 0) begin
                        d = ~d;
                    end else if (d == CMD_SECTOR) begin
                        sectors_left--;
                        erased_bases.push_back(off & ~SECTOR_MASK);
                    end else begin
                        blocks_left--;
                        erased_bases.push_back(off & ~BLOCK_MASK);
                    end
                end
                unlock_pair();
                seq_write(cmd_addr(ADDR_UNLOCK1), CMD_ERASE);
                unlock_pair();
                seq_write(win(off), d);
            end else if (pick < 60) begin
                // ID mode: reads and ignored writes, always left with the exit byte
                unlock_pair();
                seq_write(cmd_addr(ADDR_UNLOCK1), CMD_ID);
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    if ($urandom_range(0, 3) == 0) begin
                        d = 8'($urandom);
                        if (d == CMD_ID_EXIT) d = ~d;
                        put_request(OP_WRITE, win(t_addr'($urandom)), d, 1'b0, 8'h00);
                    end else begin
                        put_request(OP_READ, win(t_addr'($urandom)), 8'($urandom), 1'b0, 8'h00);
                    end
                end
                put_request(OP_WRITE, win(t_addr'($urandom)), CMD_ID_EXIT, 1'b0, 8'h00);
            end else if (pick < 70) begin
                // lock registers; lock-down is rare since it sticks until reset
                b = t_blk'($urandom);
                a = LOCK_ADDR_MATCH | (32'(b) << 16);
                if ($urandom_range(0, 1) != 0) begin
                    put_request(OP_READ, a, 8'($urandom), 1'b0, 8'h00);
                end else begin
                    d = 8'($urandom);
                    if ($urandom_range(0, 39) != 0) d[LK_DOWN] = 1'b0;
                    if ($urandom_range(0, 3) != 0) d[LK_READ] = 1'b0;
                    if ($urandom_range(0, 2) != 0) d[LK_WRITE] = 1'b0;
                    put_request(OP_WRITE, a, d, 1'b0, 8'h00);
                end
            end else if (pick < 78) begin
                // below the window
                a = $urandom;
                if (a >= WINDOW_BASE) a[19] = 1'b0;
                put_request(t_op'($urandom_range(0, 1)), a, 8'($urandom), 1'b0, 8'h00);
            end else begin
                // anything at all
                a = ($urandom_range(0, 1) != 0) ? $urandom : win(t_addr'($urandom));
                put_request(t_op'($urandom_range(0, 1)), a, 8'($urandom), 1'b0, 8'h00);
            end
        end

        // close on reads so a pending erase has finished before the end
        idle_pct = 0;
        repeat (2) put_request(OP_READ, win(hot_offset()), 8'h00, 1'b0, 8'h00);
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (n_errors == 0) $display("tb_flash_command_controller_top OK");
        else $display("tb_flash_command_controller_top NOT OK");
        $finish;
    end

endmodule
